// ----- rtl/prsa_pkg.sv -----
// Shared types and constants of the pointer rotate / scroll accumulator.
// Depends on nothing; every other file of the block imports it.
package prsa_pkg;

   localparam int PTR_WIDTH   = 16;
   localparam int WHEEL_WIDTH = 8;
   localparam int STEP_WIDTH  = 8;
   localparam int ACC_WIDTH   = 18;
   // Bits of the largest divisor; sets the reciprocal precision.
   localparam int DIV_BITS    = 8;

   localparam logic OP_KEY    = 1'b0;
   localparam logic OP_MOTION = 1'b1;

   localparam logic [2:0] KEY_DRAG_SCROLL  = 3'd0;
   localparam logic [2:0] KEY_DRAG_ROTATE  = 3'd1;
   localparam logic [2:0] KEY_ROTATE_RIGHT = 3'd2;
   localparam logic [2:0] KEY_ROTATE_LEFT  = 3'd3;

   localparam logic [1:0] LAYER_NONE        = 2'd0;
   localparam logic [1:0] LAYER_SET_DEFAULT = 2'd1;
   localparam logic [1:0] LAYER_GOTO        = 2'd2;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // Function layers sit above the four base layers.
   localparam logic FN_LAYER_BIT = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [2:0]                    key;
      logic                          pressed;
      logic signed [PTR_WIDTH-1:0]   motion_x;
      logic signed [PTR_WIDTH-1:0]   motion_y;
      logic signed [WHEEL_WIDTH-1:0] wheel_h;
      logic signed [WHEEL_WIDTH-1:0] wheel_v;
   } req_item_type;

   typedef struct packed {
      logic signed [PTR_WIDTH-1:0]  out_x;
      logic signed [PTR_WIDTH-1:0]  out_y;
      logic signed [STEP_WIDTH-1:0] out_h;
      logic signed [STEP_WIDTH-1:0] out_v;
      logic [1:0]                   orientation;
      logic                         drag_active;
      logic [1:0]                   layer_action;
      logic [2:0]                   layer_number;
      logic                         handled;
   } rsp_item_type;

endpackage

// ----- rtl/prsa_req_if.sv -----
// Input channel: valid/ready handshake carrying one key event or motion report.
// Depends on prsa_pkg.
interface prsa_req_if;
   import prsa_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/prsa_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
// Depends on prsa_pkg.
interface prsa_rsp_if;
   import prsa_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/prsa_scroll_acc.sv -----
// One scroll accumulator slice: saturating add, divide by DIVISOR toward zero,
// clamp to whole steps, keep the remainder. Depends on prsa_pkg.
module prsa_scroll_acc #(
   parameter int DIVISOR = 20
) (
   input  logic signed [prsa_pkg::ACC_WIDTH-1:0]  acc,
   input  logic signed [prsa_pkg::PTR_WIDTH-1:0]  add_val,
   output logic signed [prsa_pkg::ACC_WIDTH-1:0]  acc_next,
   output logic signed [prsa_pkg::STEP_WIDTH-1:0] steps
);
   import prsa_pkg::*;

   localparam int SUM_W  = ACC_WIDTH + 1;
   localparam int SHIFT  = ACC_WIDTH + DIV_BITS;
   localparam int PROD_W = ACC_WIDTH + SHIFT + 1;
   // ceil(2^SHIFT / DIVISOR): exact quotient for any ACC_WIDTH-bit magnitude
   localparam logic [SHIFT:0] RECIP =
      (SHIFT+1)'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((2 ** (ACC_WIDTH-1)) - 1);
   localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-(2 ** (ACC_WIDTH-1)));
   localparam logic [ACC_WIDTH-1:0] STEP_POS_LIM = ACC_WIDTH'((2 ** (STEP_WIDTH-1)) - 1);
   localparam logic [ACC_WIDTH-1:0] STEP_NEG_LIM = ACC_WIDTH'(2 ** (STEP_WIDTH-1));
   localparam logic signed [SUM_W-1:0] DIV_W = SUM_W'(DIVISOR);

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_sat;
   logic signed [SUM_W-1:0] sum_neg;
   logic signed [SUM_W-1:0] quot;
   logic signed [SUM_W-1:0] quot_div;
   logic signed [SUM_W-1:0] rem;
   logic                    neg;
   logic [ACC_WIDTH-1:0]    mag;
   logic [PROD_W-1:0]       prod;
   logic [ACC_WIDTH-1:0]    q_mag;
   logic [ACC_WIDTH-1:0]    q_lim;
   logic [ACC_WIDTH-1:0]    q_sat_mag;

   always_comb begin
      sum = SUM_W'(acc) + SUM_W'(add_val);
      if (sum > ACC_MAX) begin
         sum_sat = ACC_MAX;
      end else if (sum < ACC_MIN) begin
         sum_sat = ACC_MIN;
      end else begin
         sum_sat = sum;
      end

      // Divide the magnitude so truncation goes toward zero.
      neg     = sum_sat[SUM_W-1];
      sum_neg = -sum_sat;
      mag     = neg ? sum_neg[ACC_WIDTH-1:0] : sum_sat[ACC_WIDTH-1:0];
      prod    = PROD_W'(mag) * PROD_W'(RECIP);
      q_mag   = prod[PROD_W-2:SHIFT];

      q_lim     = neg ? STEP_NEG_LIM : STEP_POS_LIM;
      q_sat_mag = (q_mag > q_lim) ? q_lim : q_mag;
      quot      = neg ? -SUM_W'(q_sat_mag) : SUM_W'(q_sat_mag);

      quot_div = quot * DIV_W;
      rem      = sum_sat - quot_div;
      acc_next = rem[ACC_WIDTH-1:0];
      steps    = quot[STEP_WIDTH-1:0];
   end

endmodule

// ----- rtl/pointer_rotate_scroll_accumulator_unit.sv -----
// Pointer rotate / drag-scroll accumulator, top level.
// Depends on prsa_pkg, prsa_req_if, prsa_rsp_if and prsa_scroll_acc.
//
// Usage:
//   req_bus carries one word per handshake: a key event (op = 0) or a motion
//   report (op = 1). rsp_bus returns exactly one result word for each
//   request word, in order.
//   Key events set or clear drag-scroll mode, turn the orientation a quarter
//   turn and report layer actions. Motion reports are rotated by the
//   orientation; in drag mode the pointer motion feeds the scroll accumulators
//   and the pointer output is zero, otherwise the wheel values feed them.
//   Each request word passes through the input register, then the result
//   register. Throughput: one word per cycle while rsp_bus.ready is high; the
//   whole step, including the divide-by-DIVISOR done as one reciprocal
//   multiply per accumulator, runs between the input and result registers.
//   Stall: when rsp_bus.ready is low the result register holds its word;
//   the input register still takes one more word, after which req_bus.ready
//   drops until the result is taken.
//   Reset (synchronous, active high): orientation 0, drag mode off, both
//   accumulators zero, both pipeline registers empty.
module pointer_rotate_scroll_accumulator_unit #(
   parameter int DIVISOR = 20
) (
   input logic         clock,
   input logic         reset,
   prsa_req_if.sink    req_bus,
   prsa_rsp_if.source  rsp_bus
);
   import prsa_pkg::*;

   // Pipeline registers
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;

   // Architectural state
   logic [1:0]                  rot_ff;
   logic [1:0]                  rot_in;
   logic                        drag_ff;
   logic                        drag_in;
   logic signed [ACC_WIDTH-1:0] acc_h_ff;
   logic signed [ACC_WIDTH-1:0] acc_h_in;
   logic signed [ACC_WIDTH-1:0] acc_v_ff;
   logic signed [ACC_WIDTH-1:0] acc_v_in;

   // Datapath
   logic                          advance;
   logic                          take_req;
   logic signed [PTR_WIDTH-1:0]   x_rot;
   logic signed [PTR_WIDTH-1:0]   y_rot;
   logic signed [WHEEL_WIDTH:0]   wh_ext;
   logic signed [WHEEL_WIDTH:0]   wv_ext;
   logic signed [WHEEL_WIDTH:0]   h_rot;
   logic signed [WHEEL_WIDTH:0]   v_rot;
   logic signed [PTR_WIDTH-1:0]   add_h;
   logic signed [PTR_WIDTH-1:0]   add_v;
   logic signed [ACC_WIDTH-1:0]   acc_h_next;
   logic signed [ACC_WIDTH-1:0]   acc_v_next;
   logic signed [STEP_WIDTH-1:0]  steps_h;
   logic signed [STEP_WIDTH-1:0]  steps_v;

   // Advance the held word when the result register is free or being drained.
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign take_req      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

   // Rotate pointer and wheel by the current orientation. Pointer negation
   // wraps in 16 bits; wheel negation is carried in 9 bits so -128 turns into
   // +128 without wrapping.
   always_comb begin
      wh_ext = (WHEEL_WIDTH+1)'(s1_item_ff.wheel_h);
      wv_ext = (WHEEL_WIDTH+1)'(s1_item_ff.wheel_v);
      case (rot_ff)
         ROT_90: begin
            x_rot = -s1_item_ff.motion_y;
            y_rot = s1_item_ff.motion_x;
            h_rot = -wv_ext;
            v_rot = wh_ext;
         end
         ROT_180: begin
            x_rot = -s1_item_ff.motion_x;
            y_rot = -s1_item_ff.motion_y;
            h_rot = -wh_ext;
            v_rot = -wv_ext;
         end
         ROT_270: begin
            x_rot = s1_item_ff.motion_y;
            y_rot = -s1_item_ff.motion_x;
            h_rot = wv_ext;
            v_rot = -wh_ext;
         end
         default: begin
            x_rot = s1_item_ff.motion_x;
            y_rot = s1_item_ff.motion_y;
            h_rot = wh_ext;
            v_rot = wv_ext;
         end
      endcase
      // Drag mode scrolls with the pointer, otherwise with the wheel.
      add_h = drag_ff ? x_rot : PTR_WIDTH'(h_rot);
      add_v = drag_ff ? y_rot : PTR_WIDTH'(v_rot);
   end

   prsa_scroll_acc #(.DIVISOR(DIVISOR)) u_acc_h (
      .acc      (acc_h_ff),
      .add_val  (add_h),
      .acc_next (acc_h_next),
      .steps    (steps_h)
   );

   prsa_scroll_acc #(.DIVISOR(DIVISOR)) u_acc_v (
      .acc      (acc_v_ff),
      .add_val  (add_v),
      .acc_next (acc_v_next),
      .steps    (steps_v)
   );

   // One step of the block for the word in the input register.
   always_comb begin
      rot_in   = rot_ff;
      drag_in  = drag_ff;
      acc_h_in = acc_h_ff;
      acc_v_in = acc_v_ff;
      rsp_in   = '0;

      if (s1_item_ff.op == OP_KEY) begin
         case (s1_item_ff.key)
            KEY_DRAG_SCROLL: begin
               drag_in = s1_item_ff.pressed;
            end
            KEY_DRAG_ROTATE: begin
               // Press enters the rotated function layer, release leaves it.
               drag_in             = s1_item_ff.pressed;
               rsp_in.layer_action = LAYER_GOTO;
               rsp_in.layer_number = {s1_item_ff.pressed & FN_LAYER_BIT, rot_ff};
               rsp_in.handled      = 1'b1;
            end
            KEY_ROTATE_RIGHT, KEY_ROTATE_LEFT: begin
               if (s1_item_ff.pressed) begin
                  rot_in = (s1_item_ff.key == KEY_ROTATE_RIGHT) ? rot_ff + 2'd1
                                                                : rot_ff - 2'd1;
                  rsp_in.layer_action = LAYER_SET_DEFAULT;
                  rsp_in.layer_number = {1'b0, rot_in};
               end
               rsp_in.handled = 1'b1;
            end
            default: begin
               // Unrelated key: pass through untouched.
               rsp_in.handled = 1'b0;
            end
         endcase
      end else begin
         acc_h_in     = acc_h_next;
         acc_v_in     = acc_v_next;
         rsp_in.out_h = steps_h;
         rsp_in.out_v = steps_v;
         if (!drag_ff) begin
            rsp_in.out_x = x_rot;
            rsp_in.out_y = y_rot;
         end
      end

      rsp_in.orientation = rot_in;
      rsp_in.drag_active = drag_in;
   end

   always_comb begin
      s1_valid_in  = take_req || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rot_ff       <= ROT_0;
         drag_ff      <= 1'b0;
         acc_h_ff     <= '0;
         acc_v_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            rot_ff   <= rot_in;
            drag_ff  <= drag_in;
            acc_h_ff <= acc_h_in;
            acc_v_ff <= acc_v_in;
         end
      end
   end

   // Payload registers: load on handshake / advance, hold otherwise.
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_item_ff <= req_bus.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // State may only move when a word advances into the result register.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rot_ff) && $stable(drag_ff)
                   && $stable(acc_h_ff) && $stable(acc_v_ff))
      else $error("state changed without an advancing word");

   // Key events produce no pointer motion and no scroll steps.
   a_key_no_motion: assert property (@(posedge clock) disable iff (reset)
      advance && (s1_item_ff.op == OP_KEY) |=>
         rsp_ff.out_x == '0 && rsp_ff.out_y == '0
         && rsp_ff.out_h == '0 && rsp_ff.out_v == '0)
      else $error("key event result carries motion");

   // Pointer output is silenced while drag-scrolling.
   a_drag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drag_active |-> rsp_ff.out_x == '0 && rsp_ff.out_y == '0)
      else $error("pointer motion reported in drag mode");

   // No layer action means no layer number.
   a_layer_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.layer_action == LAYER_NONE |-> rsp_ff.layer_number == '0)
      else $error("layer number without layer action");

endmodule
